### rtl/core/chash_pkg.sv
// Shared widths, constants and queue types for the case-insensitive string hash.
package chash_pkg;

  localparam int ACC_W        = 32;
  localparam int CODE_W       = 8;
  localparam int SLOT_W       = 31;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [ACC_W-1:0]  HASH_SEED    = 32'd1447;
  localparam logic [ACC_W-1:0]  COUNT_START  = 32'd3;
  localparam logic [ACC_W-1:0]  COUNT_WEIGHT = 32'd7;
  localparam logic [SLOT_W-1:0] TABLE_SIZE_RESET = 31'd29;

  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] acc;
  } queue_push_t;

  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] acc;
  } queue_pop_t;

endpackage

### rtl/core/chash_if.sv
// Valid/ready channel interfaces for key bytes and hash slots.
interface chash_char_if import chash_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface chash_slot_if import chash_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output slot, input ready);
  modport sink (input valid, input slot, output ready);
endinterface

### rtl/core/chash_front.sv
// Front end: folds case and accumulates each key byte, queues the finished hash.
module chash_front import chash_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  chash_char_if.sink   key,
  output queue_push_t  push,
  input  logic         full
);

  localparam logic [CODE_W-1:0] UPPER_FIRST = 8'h41;
  localparam logic [CODE_W-1:0] UPPER_LAST  = 8'h5A;
  localparam logic [CODE_W-1:0] CASE_OFFSET = 8'h20;
  localparam logic [CODE_W-1:0] TERMINATOR  = 8'h00;

  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]  cnt;
  logic [CODE_W-1:0] folded;
  logic [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]  weight;
  logic              take;
  logic              is_end;

  assign key.ready = !full;
  assign take      = key.valid && key.ready;
  assign is_end    = key.char_code == TERMINATOR;

  always_comb begin
    if (key.char_code >= UPPER_FIRST && key.char_code <= UPPER_LAST) begin
      folded = key.char_code + CASE_OFFSET;
    end else begin
      folded = key.char_code;
    end
  end

  assign prod     = acc * {{(ACC_W-CODE_W){1'b0}}, folded};
  assign weight   = cnt * COUNT_WEIGHT;
  assign acc_next = prod + weight;

  assign push.valid = take && is_end;
  assign push.acc   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= HASH_SEED;
      cnt <= COUNT_START;
    end else if (take) begin
      if (is_end) begin
        acc <= HASH_SEED;
        cnt <= COUNT_START;
      end else begin
        acc <= acc_next;
        cnt <= cnt + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (take && is_end) |=> (acc == HASH_SEED && cnt == COUNT_START))
    else $error("state not restarted after end of key");
`endif

endmodule

### rtl/core/chash_fifo.sv
// Short queue of finished accumulators between front and back.
module chash_fifo import chash_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  queue_push_t push,
  output logic        full,
  output queue_pop_t  pop,
  input  logic        pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [ACC_W-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == CW'(DEPTH);
  assign pop.valid = count != '0;
  assign pop.acc   = mem[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

### rtl/core/chash_mod.sv
// Back end: reduces a queued accumulator modulo the table size, one bit per cycle.
module chash_mod import chash_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SLOT_W-1:0] cfg_wr_data,
  input  queue_pop_t        pop,
  output logic              pop_ready,
  chash_slot_if.source      hash
);

  localparam int BW = $clog2(ACC_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] table_size;
  logic [ACC_W-1:0]  dividend;
  logic [SLOT_W-1:0] rem;
  logic [SLOT_W-1:0] rem_next;
  logic [ACC_W-1:0]  rem_shift;
  logic [ACC_W-1:0]  divisor;
  logic [BW-1:0]     bit_cnt;
  logic [SLOT_W-1:0] slot;

  assign pop_ready  = state == ST_IDLE;
  assign hash.valid = state == ST_DONE;
  assign hash.slot  = slot;

  assign divisor   = {1'b0, table_size};
  assign rem_shift = {rem, dividend[ACC_W-1]};

  always_comb begin
    if (rem_shift >= divisor) begin
      rem_next = SLOT_W'(rem_shift - divisor);
    end else begin
      rem_next = rem_shift[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop.valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (bit_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (hash.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        dividend <= pop.acc;
        rem      <= '0;
        bit_cnt  <= BW'(ACC_W - 1);
      end
      ST_RUN: begin
        dividend <= {dividend[ACC_W-2:0], 1'b0};
        rem      <= rem_next;
        bit_cnt  <= bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          slot <= (table_size == '0) ? '0 : rem_next;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (hash.valid && table_size != '0) |-> (slot < table_size))
    else $error("slot not below table size");
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    (pop.valid && pop_ready) |=> (state == ST_RUN))
    else $error("reduction did not start after dequeue");
`endif

endmodule

### rtl/core/case_insensitive_string_hash_unit.sv
// Top level of the case-insensitive string hash.
// Key bytes: one beat per cycle, accepted whenever the result queue has room.
// Result: the terminating beat is queued, then reduced by a bit-serial
// remainder unit; slot goes valid when that reduction ends, which starts once the back end is idle.
// The remainder unit takes a new string only after the previous slot has been accepted.
// Synchronous reset restarts the hash state, empties the queue, sets table size to 29.
module case_insensitive_string_hash_unit import chash_pkg::*; #(
  parameter int FIFO_DEPTH = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SLOT_W-1:0] cfg_wr_data,
  chash_char_if.sink        key,
  chash_slot_if.source      hash
);

  queue_push_t push;
  queue_pop_t  pop;
  logic        full;
  logic        pop_ready;

  chash_front u_front (
    .clk  (clk),
    .rst  (rst),
    .key  (key),
    .push (push),
    .full (full)
  );

  chash_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pop       (pop),
    .pop_ready (pop_ready)
  );

  chash_mod u_mod (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pop         (pop),
    .pop_ready   (pop_ready),
    .hash        (hash)
  );

endmodule

### dv/tb_case_insensitive_string_hash_unit.sv
`timescale 1ns / 1ps
// Testbench for the case-insensitive string hash: directed and random keys checked against a predictor.
module tb_case_insensitive_string_hash_unit;
  import chash_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRESSURE_HOLD = 400;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_BEATS = 64;
  localparam logic [SLOT_W-1:0] MAX_TABLE_SIZE = '1;
  localparam logic [CODE_W-1:0] END_OF_KEY = '0;
  localparam logic [CODE_W-1:0] CASE_OFFSET = 8'h20;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [SLOT_W-1:0] cfg_wr_data;

  chash_char_if key_if();
  chash_slot_if hash_if();

  case_insensitive_string_hash_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .key(key_if),
    .hash(hash_if)
  );

  logic [ACC_W-1:0] hash_acc;
  logic [ACC_W-1:0] key_position;
  logic [SLOT_W-1:0] table_size;
  logic [SLOT_W-1:0] expected_slots[$];
  logic [SLOT_W-1:0] want_slot;

  int errors = 0;
  int beats_sent = 0;
  int slots_checked = 0;
  int sizes_written = 0;
  int long_hold = 0;
  bit key_gaps_on = 1'b0;
  bit hash_stalls_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d slots outstanding", $time, expected_slots.size());
    $display("tb_case_insensitive_string_hash_unit: errors");
    $finish;
  end

  function automatic logic [ACC_W-1:0] fold_case_code(logic [CODE_W-1:0] c);
    if (c >= "A" && c <= "Z") begin
      return ACC_W'(c + CASE_OFFSET);
    end
    return ACC_W'(c);
  endfunction

  function automatic logic [SLOT_W-1:0] reduce_to_slot(logic [ACC_W-1:0] acc,
                                                      logic [SLOT_W-1:0] tsize);
    logic [ACC_W-1:0] rem;
    if (tsize == '0) begin
      return '0;
    end
    rem = acc % {1'b0, tsize};
    return rem[SLOT_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CODE_W-1:0] random_key_byte();
    case ($urandom_range(0, 3))
      0: begin
        return CODE_W'($urandom_range("A", "Z"));
      end
      1: begin
        return CODE_W'($urandom_range("a", "z"));
      end
      2: begin
        return CODE_W'($urandom_range(8'h80, 8'hFF));
      end
      default: begin
        return CODE_W'($urandom_range(8'h01, 8'hFF));
      end
    endcase
  endfunction

  // predict on accepted key beats, check accepted slot beats
  always @(posedge clk) begin
    if (rst) begin
      hash_acc = HASH_SEED;
      key_position = COUNT_START;
      table_size = TABLE_SIZE_RESET;
    end else begin
      if (hash_if.valid && hash_if.ready) begin
        if (expected_slots.size() == 0) begin
          errors++;
          $display("%0t: slot %0d with no string pending", $time, hash_if.slot);
        end else begin
          want_slot = expected_slots.pop_front();
          slots_checked++;
          if (want_slot !== hash_if.slot) begin
            errors++;
            $display("%0t: slot mismatch, expected %0d, actual %0d", $time, want_slot,
                     hash_if.slot);
          end
        end
      end
      if (cfg_wr_en) begin
        table_size = cfg_wr_data;
      end
      if (key_if.valid && key_if.ready) begin
        if (key_if.char_code == END_OF_KEY) begin
          expected_slots.push_back(reduce_to_slot(hash_acc, table_size));
          hash_acc = HASH_SEED;
          key_position = COUNT_START;
        end else begin
          hash_acc = hash_acc * fold_case_code(key_if.char_code) + key_position * COUNT_WEIGHT;
          key_position = key_position + 1;
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    hash_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        hash_if.ready <= 1'b0;
        long_hold--;
      end else if (stall_left > 0) begin
        hash_if.ready <= 1'b0;
        stall_left--;
      end else begin
        hash_if.ready <= 1'b1;
        if (hash_stalls_on && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  task automatic send_byte(input logic [CODE_W-1:0] code);
    int gap;
    @(negedge clk);
    key_if.valid <= 1'b1;
    key_if.char_code <= code;
    do @(posedge clk); while (!key_if.ready);
    beats_sent++;
    gap = key_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      key_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_key(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(random_key_byte());
    end
    send_byte(END_OF_KEY);
  endtask

  task automatic send_run(input logic [CODE_W-1:0] code, input int len);
    repeat (len) send_byte(code);
    send_byte(END_OF_KEY);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    key_if.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [SLOT_W-1:0] tsize);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= tsize;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sizes_written++;
  endtask

  task automatic test_case_folding();
    logic [CODE_W-1:0] codes[18];
    codes = '{8'h40, "A", "Z", 8'h5B, 8'h60, "a", "z", 8'h7B, END_OF_KEY,
              8'h01, 8'h80, 8'hFF, END_OF_KEY,
              END_OF_KEY,
              "A", END_OF_KEY,
              "a", END_OF_KEY};
    key_gaps_on = 1'b0;
    hash_stalls_on = 1'b0;
    foreach (codes[i]) begin
      send_byte(codes[i]);
    end
  endtask

  task automatic test_table_size_extremes();
    logic [SLOT_W-1:0] sizes[6];
    sizes = '{31'd1, MAX_TABLE_SIZE, 31'd0, 31'd2, 31'h4000_0000, TABLE_SIZE_RESET};
    key_gaps_on = 1'b1;
    hash_stalls_on = 1'b1;
    foreach (sizes[i]) begin
      write_table_size(sizes[i]);
      send_key(0);
      send_key($urandom_range(1, 5));
      send_run(8'hFF, 10);
      send_run("Z", 6);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    key_gaps_on = 1'b0;
    hash_stalls_on = 1'b0;
    long_hold = PRESSURE_HOLD;
    repeat (12) send_key($urandom_range(0, 2));
  endtask

  task automatic test_random_keys();
    int start_beats;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          write_table_size(SLOT_W'($urandom_range(1, 7)));
        end
        1: begin
          write_table_size(SLOT_W'($urandom_range(1, MAX_TABLE_SIZE)));
        end
        2: begin
          write_table_size(MAX_TABLE_SIZE);
        end
        default: begin
          write_table_size(SLOT_W'($urandom_range(8, 1000)));
        end
      endcase
      key_gaps_on = (ph % 4 == 0) || (ph % 4 == 2);
      hash_stalls_on = (ph % 4 == 0) || (ph % 4 == 3);
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_key($urandom_range(20, 40));
        end else begin
          send_key($urandom_range(0, 8));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    key_if.valid = 1'b0;
    key_if.char_code = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_case_folding();
    test_table_size_extremes();
    test_backpressure();
    test_random_keys();
    wait_idle();

    $display("run covered %0d key beats and %0d hashed strings across %0d table sizes,",
             beats_sent, slots_checked, sizes_written);
    $display("including zero and maximum table size, case folding and a long output hold");
    if (errors == 0) begin
      $display("tb_case_insensitive_string_hash_unit: clean");
    end else begin
      $display("tb_case_insensitive_string_hash_unit: errors");
    end
    $finish;
  end

endmodule
